FILE: rtl/gsab_pkg.sv
package gsab_pkg;

    localparam int ImageWidth  = 256;
    localparam int ImageHeight = 256;
    localparam int MaxRadius   = 63;
    localparam int AddrW       = 16;
    localparam int StoreDepth  = 65536;

    localparam logic [16:0] TOne     = 17'd65536;
    localparam logic [16:0] TMin     = 17'd7;
    localparam logic [15:0] AlphaMax = 16'd64881;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    typedef enum logic [1:0] {
        OP_SPLAT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BG_RED    = 2'd1;
    localparam logic [1:0] REG_BG_GREEN  = 2'd2;
    localparam logic [1:0] REG_BG_BLUE   = 2'd3;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [23:0] depth;
        logic [16:0] trans;
        logic [15:0] count;
    } pixel_t;

    localparam int PixelW = 16 * 3 + 24 + 17 + 16;

    function automatic logic [15:0] pow2_neg16(input logic [4:0] k);
        logic [15:0] v;
        begin
            case (k)
                5'd0:    v = 16'd65535;
                5'd1:    v = 16'd62757;
                5'd2:    v = 16'd60097;
                5'd3:    v = 16'd57549;
                5'd4:    v = 16'd55109;
                5'd5:    v = 16'd52773;
                5'd6:    v = 16'd50535;
                5'd7:    v = 16'd48393;
                5'd8:    v = 16'd46341;
                5'd9:    v = 16'd44376;
                5'd10:   v = 16'd42495;
                5'd11:   v = 16'd40693;
                5'd12:   v = 16'd38968;
                5'd13:   v = 16'd37316;
                5'd14:   v = 16'd35734;
                5'd15:   v = 16'd34219;
                5'd16:   v = 16'd32768;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/gsab_store.sv
module gsab_store
    import gsab_pkg::*;
(
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [AddrW-1:0]        rd_addr,
    output logic [PixelW-1:0]       rd_data,
    input  logic                    wr_en,
    input  logic [AddrW-1:0]        wr_addr,
    input  logic [PixelW-1:0]       wr_data
);

    logic [PixelW-1:0] mem [StoreDepth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/gaussian_splat_alpha_blend_core.sv
// Pixel stores live in one 65536-entry synchronous memory, one word per pixel.
// A splat visits each pixel of its box through the box step, read, two multiply steps,
// sum, exponent, alpha, weight and blend; a blended pixel then takes a write-back step,
// a skipped one does not. After the last pixel the core returns to idle for the next
// request. A read registers its result and presents it, and only once that result is
// taken admits the next request. A clear sweeps every entry; reset starts that same pass, with no requests.
module gaussian_splat_alpha_blend_core
    import gsab_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, center_x, center_y, splat_radius, conic_xx, conic_xy, conic_yy,
    // splat_red, splat_green, splat_blue, splat_opacity, splat_depth; 200 bits.
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_red, pixel_green, pixel_blue, pixel_depth, pixel_opacity,
    // contributor_count; 104 bits.
    output logic [103:0] m_tdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BOX, S_RD, S_Q1, S_Q2, S_Q3, S_EXP1, S_EXP2,
        S_ALPHA, S_W, S_BLEND, S_WB, S_RDOUT, S_OUT1, S_OUT2
    } state_t;

    state_t state_reg;
    logic [15:0] thr_reg, bgr_reg, bgg_reg, bgb_reg;
    logic [AddrW-1:0] clr_reg;

    logic signed [13:0] cx_reg, cy_reg;
    logic signed [23:0] ca_reg, cb_reg, cc_reg;
    logic [15:0] sr_reg, sg_reg, sb_reg, op_reg;
    logic [23:0] dep_reg;

    logic signed [15:0] x0_reg, x1_reg, y1_reg, x_reg, y_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [47:0] pa_reg, pb_reg, pc_reg;
    logic signed [63:0] q_reg;
    logic [34:0] t_reg;
    logic [16:0] e_reg;
    logic [15:0] alpha_reg, w_reg;
    logic        skip_reg;
    pixel_t      pix_reg;
    logic [103:0] out_reg;
    logic        outv_reg;

    logic               rd_en, wr_en;
    logic [AddrW-1:0]   rd_addr, wr_addr;
    logic [PixelW-1:0]  rd_data, wr_data;

    gsab_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pixel_t clear_pix;
    assign clear_pix = '{red: 16'd0, green: 16'd0, blue: 16'd0, depth: 24'd0,
                         trans: TOne, count: 16'd0};

    logic [AddrW-1:0] pix_addr;
    logic [31:0] lin;
    assign lin = 32'($signed(y_reg)) * 32'(ImageWidth) + 32'($signed(x_reg));
    assign pix_addr = lin[AddrW-1:0];

    assign rd_en = (state_reg == S_RD) || (state_reg == S_RDOUT);
    assign rd_addr = pix_addr;
    assign wr_en = (state_reg == S_CLEAR) || (state_reg == S_WB);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : pix_addr;
    assign wr_data = (state_reg == S_CLEAR) ? PixelW'(clear_pix) : PixelW'(pix_reg);

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {16'd0, thr_reg};
            REG_BG_RED:    prdata = {16'd0, bgr_reg};
            REG_BG_GREEN:  prdata = {16'd0, bgg_reg};
            REG_BG_BLUE:   prdata = {16'd0, bgb_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata = out_reg;

    // Box bounds with truncation toward zero.
    function automatic logic signed [15:0] div16t(input logic signed [15:0] v);
        logic [15:0] m;
        begin
            m = v[15] ? 16'(-v) : v;
            m = m >> 4;
            return v[15] ? -$signed(m) : $signed(m);
        end
    endfunction

    logic signed [15:0] r16, bx0, bx1, by0, by1;
    logic [5:0] rin;
    logic signed [13:0] icx, icy;
    assign rin = s_tdata[35:30];
    assign icx = s_tdata[15:2];
    assign icy = s_tdata[29:16];
    assign r16 = $signed({6'd0, (rin > 6'(MaxRadius)) ? 6'(MaxRadius) : rin, 4'd0});
    assign bx0 = div16t(16'(icx) - r16);
    assign bx1 = div16t(16'(icx) + r16);
    assign by0 = div16t(16'(icy) - r16);
    assign by1 = div16t(16'(icy) + r16);

    logic [15:0] tk0, tk1, tdif;
    logic [4:0]  tk;
    logic [23:0] tprod;
    assign tk = {1'b0, t_reg[11:8]};
    assign tk0 = pow2_neg16(tk);
    assign tk1 = pow2_neg16(tk + 5'd1);
    assign tdif = (tk == 5'd0) ? (16'd65535 - tk1 + 16'd1) : (tk0 - tk1);
    assign tprod = tdif * t_reg[7:0];

    logic [16:0] ebase;
    assign ebase = ((tk == 5'd0) ? 17'd65536 : {1'b0, tk0}) - 17'(tprod >> 8);

    pixel_t cur;
    assign cur = pixel_t'(rd_data);

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    logic [31:0] mr, mg, mb, mt;
    logic [39:0] md;
    logic [16:0] nr, ng, nb;
    logic [24:0] nd;
    assign mr = sr_reg * w_reg;
    assign mg = sg_reg * w_reg;
    assign mb = sb_reg * w_reg;
    assign md = dep_reg * w_reg;
    assign nr = 17'(pix_reg.red) + 17'(mr >> 16);
    assign ng = 17'(pix_reg.green) + 17'(mg >> 16);
    assign nb = 17'(pix_reg.blue) + 17'(mb >> 16);
    assign nd = 25'(pix_reg.depth) + 25'(md >> 16);
    logic [33:0] tnew;
    assign tnew = pix_reg.trans * (TOne - 17'(alpha_reg));
    logic [32:0] wprod;
    assign wprod = alpha_reg * pix_reg.trans;
    logic [31:0] aprod;
    assign aprod = 32'(op_reg) * 32'(e_reg);

    logic [32:0] br, bg, bb;
    logic [16:0] oop;
    assign br = bgr_reg * cur.trans;
    assign bg = bgg_reg * cur.trans;
    assign bb = bgb_reg * cur.trans;
    assign oop = TOne - cur.trans;

    logic inside_rd;
    assign inside_rd = (cx_reg >= 0) && (cx_reg < 14'(ImageWidth))
                    && (cy_reg >= 0) && (cy_reg < 14'(ImageHeight));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            thr_reg   <= 16'd257;
            bgr_reg   <= '0;
            bgg_reg   <= '0;
            bgb_reg   <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_THRESHOLD: thr_reg <= pwdata[15:0];
                    REG_BG_RED:    bgr_reg <= pwdata[15:0];
                    REG_BG_GREEN:  bgg_reg <= pwdata[15:0];
                    REG_BG_BLUE:   bgb_reg <= pwdata[15:0];
                    default:       thr_reg <= thr_reg;
                endcase
            end
            if (outv_reg && m_tready)
            begin
                outv_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cx_reg  <= icx;
                        cy_reg  <= icy;
                        ca_reg  <= s_tdata[59:36];
                        cb_reg  <= s_tdata[83:60];
                        cc_reg  <= s_tdata[107:84];
                        sr_reg  <= s_tdata[123:108];
                        sg_reg  <= s_tdata[139:124];
                        sb_reg  <= s_tdata[155:140];
                        op_reg  <= s_tdata[171:156];
                        dep_reg <= s_tdata[195:172];
                        x0_reg  <= (bx0 < 0) ? 16'sd0 : bx0;
                        x_reg   <= (bx0 < 0) ? 16'sd0 : bx0;
                        y_reg   <= (by0 < 0) ? 16'sd0 : by0;
                        x1_reg  <= (bx1 > 16'(ImageWidth - 1)) ? 16'(ImageWidth - 1) : bx1;
                        y1_reg  <= (by1 > 16'(ImageHeight - 1)) ? 16'(ImageHeight - 1) : by1;
                        case (op_t'(s_tdata[1:0]))
                            OP_SPLAT: state_reg <= S_BOX;
                            OP_READ:
                            begin
                                x_reg <= 16'(icx);
                                y_reg <= 16'(icy);
                                state_reg <= S_RDOUT;
                            end
                            OP_CLEAR:
                            begin
                                clr_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_BOX:
                begin
                    if (x_reg > x1_reg || y_reg > y1_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        dx_reg <= 16'(cx_reg) - (x_reg <<< 4);
                        dy_reg <= 16'(cy_reg) - (y_reg <<< 4);
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    pa_reg <= 48'(ca_reg) * 48'(dx_reg);
                    pb_reg <= 48'(cb_reg) * 48'(dx_reg);
                    pc_reg <= 48'(cc_reg) * 48'(dy_reg);
                    state_reg <= S_Q1;
                end
                S_Q1:
                begin
                    pix_reg <= cur;
                    skip_reg <= cur.trans < TMin;
                    pa_reg <= pa_reg * 48'(dx_reg);
                    pb_reg <= (pb_reg * 48'(dy_reg)) <<< 1;
                    pc_reg <= pc_reg * 48'(dy_reg);
                    state_reg <= S_Q2;
                end
                S_Q2:
                begin
                    q_reg <= 64'(pa_reg) + 64'(pb_reg) + 64'(pc_reg);
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    if (q_reg < 0)
                    begin
                        skip_reg <= 1'b1;
                    end
                    if (q_reg >= (64'sd1 <<< 30))
                    begin
                        t_reg <= 35'h7FFFFFFFF;
                    end
                    else
                    begin
                        t_reg <= 35'((48'(q_reg[29:0]) * 48'(Log2eQ16)) >> 29);
                    end
                    state_reg <= S_EXP1;
                end
                S_EXP1:
                begin
                    if (t_reg[34:12] > 23'd16)
                    begin
                        e_reg <= 17'd0;
                    end
                    else
                    begin
                        e_reg <= ebase >> t_reg[16:12];
                    end
                    state_reg <= S_EXP2;
                end
                S_EXP2:
                begin
                    alpha_reg <= (aprod[31:16] > AlphaMax) ? AlphaMax : aprod[31:16];
                    state_reg <= S_ALPHA;
                end
                S_ALPHA:
                begin
                    if (alpha_reg < thr_reg)
                    begin
                        skip_reg <= 1'b1;
                    end
                    w_reg <= wprod[31:16];
                    state_reg <= S_W;
                end
                S_W:
                begin
                    state_reg <= skip_reg ? S_BLEND : S_BLEND;
                    if (!skip_reg)
                    begin
                        pix_reg.red   <= sat16(nr);
                        pix_reg.green <= sat16(ng);
                        pix_reg.blue  <= sat16(nb);
                        pix_reg.depth <= nd[24] ? 24'hFFFFFF : nd[23:0];
                        pix_reg.trans <= tnew[32:16];
                        pix_reg.count <= (&pix_reg.count) ? pix_reg.count
                                                          : pix_reg.count + 16'd1;
                    end
                end
                S_BLEND:
                begin
                    state_reg <= skip_reg ? S_BOX : S_WB;
                    if (skip_reg)
                    begin
                        if (x_reg == x1_reg)
                        begin
                            x_reg <= x0_reg;
                            y_reg <= y_reg + 16'sd1;
                        end
                        else
                        begin
                            x_reg <= x_reg + 16'sd1;
                        end
                    end
                end
                S_WB:
                begin
                    state_reg <= S_BOX;
                    if (x_reg == x1_reg)
                    begin
                        x_reg <= x0_reg;
                        y_reg <= y_reg + 16'sd1;
                    end
                    else
                    begin
                        x_reg <= x_reg + 16'sd1;
                    end
                end
                S_RDOUT:
                begin
                    state_reg <= S_OUT1;
                end
                S_OUT1:
                begin
                    if (inside_rd)
                    begin
                        out_reg <= {cur.count,
                                    oop[16] ? 16'hFFFF : oop[15:0],
                                    cur.depth,
                                    sat16(17'(cur.blue) + 17'(bb >> 16)),
                                    sat16(17'(cur.green) + 17'(bg >> 16)),
                                    sat16(17'(cur.red) + 17'(br >> 16))};
                    end
                    else
                    begin
                        out_reg <= '0;
                    end
                    state_reg <= S_OUT2;
                end
                S_OUT2:
                begin
                    outv_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: test/tb_top.sv
module tb_top;
    import gsab_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t                op;
        logic signed [13:0] cx;
        logic signed [13:0] cy;
        logic [5:0]         radius;
        logic signed [23:0] cxx;
        logic signed [23:0] cxy;
        logic signed [23:0] cyy;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic [15:0]        opac;
        logic [23:0]        depth;
    } splat_req_t;

    class blend_scoreboard;
        bit [15:0] red_px[int];
        bit [15:0] grn_px[int];
        bit [15:0] blu_px[int];
        bit [23:0] dep_px[int];
        bit [16:0] tr_px[int];
        bit [15:0] cnt_px[int];
        bit [15:0] threshold = 16'd257;
        bit [15:0] bg_r;
        bit [15:0] bg_g;
        bit [15:0] bg_b;
        longint    pow_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                   48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                   35734, 34219, 32768};
        bit [103:0] pending_pixels[$];
        int         errors;

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void queue_pixel(bit [103:0] px);
            pending_pixels.insert(pending_pixels.size(), px);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_THRESHOLD: threshold = val[15:0];
                REG_BG_RED:    bg_r = val[15:0];
                REG_BG_GREEN:  bg_g = val[15:0];
                REG_BG_BLUE:   bg_b = val[15:0];
            endcase
        endfunction

        function longint trans_at(int p);
            return tr_px.exists(p) ? longint'(tr_px[p]) : 65536;
        endfunction

        function longint sat(longint v, longint top);
            return v > top ? top : v;
        endfunction

        function longint falloff(longint q);
            longint t, n, k, f, d, e;
            if (q >= (longint'(1) << 30))
                return 0;
            t = (q * 94548) >> 29;
            n = t >> 12;
            if (n > 16)
                return 0;
            k = (t >> 8) & 15;
            f = t & 255;
            d = pow_tab[k] - pow_tab[k + 1];
            e = pow_tab[k] - ((d * f) >> 8);
            return e >> n;
        endfunction

        function void blend_splat(splat_req_t r);
            longint cx, cy, rad, x0, x1, y0, y1, x, y, dx, dy, q, t, alpha, w, v;
            int p;
            cx = r.cx;
            cy = r.cy;
            rad = r.radius;
            if (rad > MaxRadius)
                rad = MaxRadius;
            x0 = (cx - 16 * rad) / 16;
            x1 = (cx + 16 * rad) / 16;
            y0 = (cy - 16 * rad) / 16;
            y1 = (cy + 16 * rad) / 16;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > ImageWidth - 1) x1 = ImageWidth - 1;
            if (y1 > ImageHeight - 1) y1 = ImageHeight - 1;
            for (y = y0; y <= y1; y++) begin
                for (x = x0; x <= x1; x++) begin
                    p = int'((y * ImageWidth + x) & 65535);
                    t = trans_at(p);
                    dx = cx - 16 * x;
                    dy = cy - 16 * y;
                    if (t < 7)
                        continue;
                    q = longint'(r.cxx) * dx * dx + longint'(r.cyy) * dy * dy
                        + 2 * longint'(r.cxy) * dx * dy;
                    if (q < 0)
                        continue;
                    alpha = (longint'(r.opac) * falloff(q)) >> 16;
                    if (alpha > 64881)
                        alpha = 64881;
                    if (alpha < threshold)
                        continue;
                    w = (alpha * t) >> 16;
                    v = red_px.exists(p) ? red_px[p] : 0;
                    red_px[p] = sat(v + ((longint'(r.red) * w) >> 16), 65535);
                    v = grn_px.exists(p) ? grn_px[p] : 0;
                    grn_px[p] = sat(v + ((longint'(r.green) * w) >> 16), 65535);
                    v = blu_px.exists(p) ? blu_px[p] : 0;
                    blu_px[p] = sat(v + ((longint'(r.blue) * w) >> 16), 65535);
                    v = dep_px.exists(p) ? dep_px[p] : 0;
                    dep_px[p] = sat(v + ((longint'(r.depth) * w) >> 16), 24'hFFFFFF);
                    tr_px[p] = (t * (65536 - alpha)) >> 16;
                    v = cnt_px.exists(p) ? cnt_px[p] : 0;
                    cnt_px[p] = sat(v + 1, 65535);
                end
            end
        endfunction

        function void note_request(splat_req_t r);
            longint x, y, t;
            bit [15:0] pr, pg, pb, po, pc;
            bit [23:0] pd;
            int p;
            case (r.op)
                OP_SPLAT: blend_splat(r);
                OP_CLEAR:
                begin
                    red_px.delete();
                    grn_px.delete();
                    blu_px.delete();
                    dep_px.delete();
                    tr_px.delete();
                    cnt_px.delete();
                end
                OP_READ:
                begin
                    x = r.cx;
                    y = r.cy;
                    if (x < 0 || x >= ImageWidth || y < 0 || y >= ImageHeight) begin
                        queue_pixel('0);
                    end else begin
                        p = int'((y * ImageWidth + x) & 65535);
                        t = trans_at(p);
                        pr = sat((red_px.exists(p) ? red_px[p] : 0) + ((bg_r * t) >> 16), 65535);
                        pg = sat((grn_px.exists(p) ? grn_px[p] : 0) + ((bg_g * t) >> 16), 65535);
                        pb = sat((blu_px.exists(p) ? blu_px[p] : 0) + ((bg_b * t) >> 16), 65535);
                        pd = dep_px.exists(p) ? dep_px[p] : 0;
                        po = sat(65536 - t, 65535);
                        pc = cnt_px.exists(p) ? cnt_px[p] : 0;
                        queue_pixel({pc, po, pd, pb, pg, pr});
                    end
                end
                default: ;
            endcase
        endfunction

        task check_result(bit [103:0] got);
            bit [103:0] want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel %h with no read pending", got));
                return;
            end
            want = pending_pixels.pop_front();
            if (got[15:0] != want[15:0])
                report($sformatf("red %0d, want %0d", got[15:0], want[15:0]));
            if (got[31:16] != want[31:16])
                report($sformatf("green %0d, want %0d", got[31:16], want[31:16]));
            if (got[47:32] != want[47:32])
                report($sformatf("blue %0d, want %0d", got[47:32], want[47:32]));
            if (got[71:48] != want[71:48])
                report($sformatf("depth %0d, want %0d", got[71:48], want[71:48]));
            if (got[87:72] != want[87:72])
                report($sformatf("opacity %0d, want %0d", got[87:72], want[87:72]));
            if (got[103:88] != want[103:88])
                report($sformatf("count %0d, want %0d", got[103:88], want[103:88]));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    blend_scoreboard sb = new();
    bit              calm;
    int              clears_left = 1;

    gaussian_splat_alpha_blend_core uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send(splat_req_t r);
        if (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, r.depth, r.opac, r.blue, r.green, r.red, r.cyy, r.cxy,
                     r.cxx, r.radius, r.cy, r.cx, r.op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    function automatic splat_req_t splat_at(int cx, int cy, int rad, int xx, int xy, int yy,
                                            logic [15:0] col, logic [15:0] opac,
                                            logic [23:0] depth);
        splat_req_t r;
        r.op = OP_SPLAT;
        r.cx = cx[13:0];
        r.cy = cy[13:0];
        r.radius = rad[5:0];
        r.cxx = xx[23:0];
        r.cxy = xy[23:0];
        r.cyy = yy[23:0];
        r.red = col;
        r.green = col;
        r.blue = col;
        r.opac = opac;
        r.depth = depth;
        return r;
    endfunction

    function automatic splat_req_t read_at(int x, int y);
        splat_req_t r;
        r = splat_at(x, y, 0, 0, 0, 0, 16'd0, 16'd0, 24'd0);
        r.op = OP_READ;
        return r;
    endfunction

    function automatic splat_req_t random_request();
        splat_req_t r;
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 55) begin
            r = splat_at($urandom_range(0, 352) - 32, $urandom_range(0, 352) - 32,
                         $urandom_range(0, 4), $urandom_range(0, 1 << 17),
                         $urandom_range(0, 65536) - 32768, $urandom_range(0, 1 << 17),
                         16'($urandom), 16'($urandom_range(20000, 65535)), 24'($urandom));
            r.green = 16'($urandom);
            r.blue = 16'($urandom);
        end else if (sel < 90) begin
            r = read_at($urandom_range(0, 23) - 2, $urandom_range(0, 23) - 2);
        end else if (sel < 98) begin
            r.op = OP_SPLAT;
            {r.cx, r.cy, r.radius} = 34'({$urandom, $urandom});
            {r.cxx, r.cxy, r.cyy} = 72'({$urandom, $urandom, $urandom});
            {r.red, r.green, r.blue, r.opac} = 64'({$urandom, $urandom});
            r.depth = 24'($urandom);
            if (r.cx > -1100 && r.cx < 5200 && r.cy > -1100 && r.cy < 5200)
                r.radius[5:2] = 4'd0;
        end else if (sel == 98 && clears_left > 0) begin
            clears_left--;
            r = read_at(0, 0);
            r.op = OP_CLEAR;
        end else begin
            v = $urandom;
            r = read_at(v[13:0], v[27:14]);
            r.op = OP_NONE;
        end
        return r;
    endfunction

    initial
    begin
        splat_req_t r;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(read_at(0, 0));
        send(splat_at(40, 40, 0, 65536, 0, 65536, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
        send(splat_at(40, 40, 1, 65536, 0, 65536, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
        send(splat_at(40, 40, 1, 65536, 0, 65536, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
        send(splat_at(40, 40, 2, 65536, 0, 65536, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
        send(read_at(2, 2));
        send(read_at(3, 2));
        send(splat_at(-8192, -8192, 63, 65536, 0, 65536, 16'h1234, 16'hFFFF, 24'd0));
        send(splat_at(8191, 8191, 63, 65536, 0, 65536, 16'h1234, 16'hFFFF, 24'd0));
        send(splat_at(96, 96, 3, -8388608, 8388607, -8388608, 16'h4000, 16'h8000, 24'd99));
        send(splat_at(160, 96, 3, 8388607, -8388608, 8388607, 16'h4000, 16'h8000, 24'd99));
        send(splat_at(2048, 2048, 63, 64, 0, 64, 16'h2000, 16'h1000, 24'h001000));
        send(read_at(128, 128));
        send(read_at(-1, 5));
        send(read_at(5, 256));
        send(read_at(8191, -8192));
        send(read_at(255, 255));
        r = read_at(1, 1);
        r.op = OP_NONE;
        send(r);
        r.op = OP_CLEAR;
        send(r);
        send(read_at(2, 2));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    write_reg(REG_THRESHOLD, 32'd0);
                    write_reg(REG_BG_RED, 32'hFFFF_FFFF);
                    write_reg(REG_BG_GREEN, 32'h0000_FFFF);
                    write_reg(REG_BG_BLUE, 32'hABCD_0000);
                end
                1:
                begin
                    write_reg(REG_THRESHOLD, 32'd65535);
                    write_reg(REG_BG_RED, 32'd0);
                    write_reg(REG_BG_GREEN, 32'd4000);
                    write_reg(REG_BG_BLUE, 32'hFFFF);
                end
                default:
                begin
                    write_reg(REG_THRESHOLD, $urandom_range(0, 3000));
                    write_reg(REG_BG_RED, $urandom);
                    write_reg(REG_BG_GREEN, $urandom);
                    write_reg(REG_BG_BLUE, $urandom);
                end
            endcase
            calm = (phase == 2);
            repeat (108)
                send(random_request());
            send(read_at(3, 3));
            drain();
        end

        repeat (200)
            @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
